// ===== hdl/edv_pkg.sv =====
// ============================================================================
// edv_pkg
// Shared constants, types and fixed-point helpers for the euler angle to
// direction vector core.
// ============================================================================
`default_nettype none

package edv_pkg;

    // angle and result formats
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int QSHIFT     = 30;
    localparam int OUT_W      = 16;
    localparam int IN_W       = 16;

    // six sine/cosine lanes: sp, cp, sy, cy, sr, cr
    localparam int LANES = 6;
    localparam int L_SP  = 0;
    localparam int L_CP  = 1;
    localparam int L_SY  = 2;
    localparam int L_CY  = 3;
    localparam int L_SR  = 4;
    localparam int L_CR  = 5;

    // series steps after the linear term
    localparam int STEPS = 8;

    localparam int U_W   = ANGLE_BITS - 1;
    localparam int X_W   = 32;
    localparam int SUM_W = 34;
    localparam int TRIG_W = 32;
    localparam int REC_W = 39;
    localparam int REC_SHIFT = 41;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [TRIG_W-1:0] QONE = TRIG_W'(1) << QSHIFT;

    // reciprocals ceil(2^41 / d) for the series divisors
    localparam logic [REC_W-1:0] RECIP [STEPS] = '{
        REC_W'(((64'd1 << REC_SHIFT) + 64'd5)   / 64'd6),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd19)  / 64'd20),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd41)  / 64'd42),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd71)  / 64'd72),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd109) / 64'd110),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd155) / 64'd156),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd209) / 64'd210),
        REC_W'(((64'd1 << REC_SHIFT) + 64'd271) / 64'd272)
    };

    // terms of odd steps are subtracted
    localparam logic [STEPS-1:0] SUB_STEP = 8'b0101_0101;

    localparam int RND_SH = QSHIFT - FRAC_BITS;
    localparam logic [31:0] RND_ADD = (RND_SH > 0) ? (32'd1 << (RND_SH - 1)) : 32'd0;

    // data handed from one series cell to the next
    typedef struct packed {
        logic [LANES-1:0][X_W-1:0]   x2;
        logic [LANES-1:0][X_W-1:0]   term;
        logic [LANES-1:0][SUM_W-1:0] sum;
        logic [LANES-1:0]            neg;
    } poly_bus_t;

    // q30 product rounded half away from zero
    function automatic logic signed [TRIG_W-1:0] mul_q30(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic        neg;
        logic [30:0] ma;
        logic [30:0] mb;
        logic [61:0] p;
        logic [TRIG_W-1:0] r;
        neg = a[TRIG_W-1] ^ b[TRIG_W-1];
        ma  = a[TRIG_W-1] ? 31'(-a) : a[30:0];
        mb  = b[TRIG_W-1] ? 31'(-b) : b[30:0];
        p   = 62'(ma) * 62'(mb) + (62'd1 << (QSHIFT - 1));
        r   = {1'b0, p[60:30]};
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // clamp to [-1,1] and round to the output fraction width
    function automatic logic [OUT_W-1:0] to_field(input logic signed [33:0] v);
        logic        neg;
        logic [31:0] m;
        logic [31:0] q;
        logic signed [31:0] r;
        neg = v[33];
        if (v > 34'sd1073741824) begin
            m = 32'd1073741824;
        end
        else if (v < -34'sd1073741824) begin
            m = 32'd1073741824;
        end
        else begin
            m = neg ? 32'(-v) : v[31:0];
        end
        q = (m + RND_ADD) >> RND_SH;
        r = neg ? -$signed(q) : $signed(q);
        return r[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/euler_direction_vectors_core.sv =====
// ============================================================================
// euler_direction_vectors_core
// Pitch, yaw and roll binary angles to forward, right and up vectors in q2.14.
// ============================================================================
// Fully pipelined: busy stays low and a transaction may be started in every
// clock cycle. Each transaction's result appears with done after it passes
// through the input capture register, angle reduction, x^2, the chain of
// eight sine-series cells (three stages each), the clamp and sign stage, the
// two product levels and the output rounding stage. The receiver cannot stall;
// results must be captured in the cycle done is high.
`default_nettype none

module euler_direction_vectors_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [edv_pkg::IN_W-1:0]    pitch_angle,
    input  wire logic [edv_pkg::IN_W-1:0]    yaw_angle,
    input  wire logic [edv_pkg::IN_W-1:0]    roll_angle,
    output logic                             done,
    output logic signed [edv_pkg::OUT_W-1:0] forward_x,
    output logic signed [edv_pkg::OUT_W-1:0] forward_y,
    output logic signed [edv_pkg::OUT_W-1:0] forward_z,
    output logic signed [edv_pkg::OUT_W-1:0] right_x,
    output logic signed [edv_pkg::OUT_W-1:0] right_y,
    output logic signed [edv_pkg::OUT_W-1:0] right_z,
    output logic signed [edv_pkg::OUT_W-1:0] up_x,
    output logic signed [edv_pkg::OUT_W-1:0] up_y,
    output logic signed [edv_pkg::OUT_W-1:0] up_z
);
    import edv_pkg::*;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;

    logic [2:0][ANGLE_BITS-1:0]  ang_reg;
    logic [LANES-1:0][X_W-1:0]   x_reg;
    logic [LANES-1:0]            neg1_reg;
    poly_bus_t                   bus0_reg;

    poly_bus_t                   bus_chain [STEPS+1];
    logic [STEPS:0]              vchain;

    logic signed [TRIG_W-1:0]    trig_reg [LANES];
    logic signed [TRIG_W-1:0]    prod_reg [9];
    logic signed [TRIG_W-1:0]    sp4_reg, sy4_reg;
    logic signed [TRIG_W-1:0]    trip0_reg, trip1_reg;
    logic signed [TRIG_W-1:0]    pass_reg [7];
    logic signed [TRIG_W-1:0]    sp5_reg, sy5_reg;
    logic signed [TRIG_W-1:0]    prod_reg_hold;
    logic [8:0][OUT_W-1:0]       out_reg;

    // control pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= vchain[STEPS];
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // capture the transaction
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ang_reg[0] <= pitch_angle[ANGLE_BITS-1:0];
            ang_reg[1] <= yaw_angle[ANGLE_BITS-1:0];
            ang_reg[2] <= roll_angle[ANGLE_BITS-1:0];
        end
    end

    // quadrant reduction and scaling to q30 radians
    always_ff @(posedge clk)
    begin
        logic [ANGLE_BITS-1:0] a;
        logic [U_W-1:0]        u;
        logic [U_W+30:0]       prod;
        for (int l = 0; l < LANES; l++)
        begin
            a = ang_reg[l/2] + ((l % 2 == 1) ? QUARTER : '0);
            if (a[ANGLE_BITS-2])
            begin
                u = U_W'(QUARTER) - U_W'(a[ANGLE_BITS-3:0]);
            end
            else
            begin
                u = U_W'(a[ANGLE_BITS-3:0]);
            end
            prod = (U_W+31)'(u) * (U_W+31)'(HALF_PI_Q30);
            x_reg[l]    <= X_W'(prod >> (ANGLE_BITS - 2));
            neg1_reg[l] <= a[ANGLE_BITS-1];
        end
    end

    // square of x, seed of the series
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            bus0_reg.x2[l]   <= X_W'((64'(x_reg[l]) * 64'(x_reg[l])) >> QSHIFT);
            bus0_reg.term[l] <= x_reg[l];
            bus0_reg.sum[l]  <= SUM_W'(x_reg[l]);
        end
        bus0_reg.neg <= neg1_reg;
    end

    assign bus_chain[0] = bus0_reg;
    assign vchain[0]    = v2_reg;

    // chain of series cells
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        edv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vchain[k]),
            .bus_in    (bus_chain[k]),
            .recip     (RECIP[k]),
            .sub_term  (SUB_STEP[k]),
            .valid_out (vchain[k+1]),
            .bus_out   (bus_chain[k+1])
        );
    end

    // clamp to [0,1] and apply quadrant sign
    always_ff @(posedge clk)
    begin
        logic signed [SUM_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
        for (int l = 0; l < LANES; l++)
        begin
            s = $signed(bus_chain[STEPS].sum[l]);
            if (s < 0)
            begin
                c = '0;
            end
            else if (s > SUM_W'(QONE))
            begin
                c = QONE;
            end
            else
            begin
                c = TRIG_W'(s);
            end
            trig_reg[l] <= bus_chain[STEPS].neg[l] ? -c : c;
        end
    end

    // first level of products
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= mul_q30(trig_reg[L_CP], trig_reg[L_SY]);
        prod_reg[1] <= mul_q30(trig_reg[L_CP], trig_reg[L_CY]);
        prod_reg[2] <= mul_q30(trig_reg[L_CR], trig_reg[L_CY]);
        prod_reg[3] <= mul_q30(trig_reg[L_SR], trig_reg[L_CY]);
        prod_reg[4] <= mul_q30(trig_reg[L_SP], trig_reg[L_SY]);
        prod_reg[5] <= mul_q30(trig_reg[L_CY], trig_reg[L_SR]);
        prod_reg[6] <= mul_q30(trig_reg[L_CP], trig_reg[L_CR]);
        prod_reg[7] <= mul_q30(trig_reg[L_SP], trig_reg[L_CY]);
        prod_reg[8] <= mul_q30(trig_reg[L_SY], trig_reg[L_SR]);
        sp4_reg     <= trig_reg[L_SP];
        sy4_reg     <= trig_reg[L_SY];
        pass_reg[6] <= trig_reg[L_CR];
    end

    // triple products for the up vector
    always_ff @(posedge clk)
    begin
        trip0_reg   <= mul_q30(prod_reg[4], pass_reg[6]);
        trip1_reg   <= mul_q30(prod_reg[7], pass_reg[6]);
        pass_reg[0] <= prod_reg[0];
        pass_reg[1] <= prod_reg[1];
        pass_reg[2] <= prod_reg[2];
        pass_reg[3] <= prod_reg[3];
        pass_reg[4] <= prod_reg[5];
        pass_reg[5] <= prod_reg[6];
        sp5_reg     <= sp4_reg;
        sy5_reg     <= sy4_reg;
        prod_reg_hold <= prod_reg[8];
    end

    // combine and round to the output format
    always_ff @(posedge clk)
    begin
        out_reg[0] <= to_field(-34'(pass_reg[0]));
        out_reg[1] <= to_field(34'(sp5_reg));
        out_reg[2] <= to_field(-34'(pass_reg[1]));
        out_reg[3] <= to_field(34'(pass_reg[2]));
        out_reg[4] <= to_field(34'(pass_reg[3]));
        out_reg[5] <= to_field(-34'(sy5_reg));
        out_reg[6] <= to_field(34'(trip0_reg) - 34'(pass_reg[4]));
        out_reg[7] <= to_field(34'(pass_reg[5]));
        out_reg[8] <= to_field(34'(trip1_reg) + 34'(prod_reg_hold));
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign forward_x = $signed(out_reg[0]);
    assign forward_y = $signed(out_reg[1]);
    assign forward_z = $signed(out_reg[2]);
    assign right_x   = $signed(out_reg[3]);
    assign right_y   = $signed(out_reg[4]);
    assign right_z   = $signed(out_reg[5]);
    assign up_x      = $signed(out_reg[6]);
    assign up_y      = $signed(out_reg[7]);
    assign up_z      = $signed(out_reg[8]);

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (sp4_reg <= QONE && sp4_reg >= -QONE))
        else $error("sine out of range");
    a_fwd_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (forward_y <= 16'sd16384 && forward_y >= -16'sd16384))
        else $error("forward_y out of range");
    a_up_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (up_x <= 16'sd16384 && up_x >= -16'sd16384))
        else $error("up_x out of range");
    a_chain_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        vchain[STEPS] |=> ##3 done)
        else $error("result lost after series chain");

endmodule

`default_nettype wire

// ===== hdl/edv_cell.sv =====
// ============================================================================
// edv_cell
// One step of the sine series for all six lanes: next term is the current
// term times x^2, divided by a constant, and added to or taken from the sum.
// Three register stages; a new transaction may enter every cycle.
// ============================================================================
`default_nettype none

module edv_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      valid_in,
    input  wire edv_pkg::poly_bus_t        bus_in,
    input  wire logic [edv_pkg::REC_W-1:0] recip,
    input  wire logic                      sub_term,
    output logic                           valid_out,
    output edv_pkg::poly_bus_t             bus_out
);
    import edv_pkg::*;

    logic [2:0] valid_reg;

    logic [LANES-1:0][X_W-1:0]   p_reg;
    logic [LANES-1:0][X_W-1:0]   x2_a_reg;
    logic [LANES-1:0][SUM_W-1:0] sum_a_reg;
    logic [LANES-1:0]            neg_a_reg;

    logic [LANES-1:0][54:0]      ph_reg;
    logic [LANES-1:0][54:0]      pl_reg;
    logic [LANES-1:0][X_W-1:0]   x2_b_reg;
    logic [LANES-1:0][SUM_W-1:0] sum_b_reg;
    logic [LANES-1:0]            neg_b_reg;

    poly_bus_t bus_reg;
    poly_bus_t bus_next;

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    // stage a: term times x^2 in q30
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            p_reg[l] <= X_W'((64'(bus_in.term[l]) * 64'(bus_in.x2[l])) >> QSHIFT);
        end
        x2_a_reg  <= bus_in.x2;
        sum_a_reg <= bus_in.sum;
        neg_a_reg <= bus_in.neg;
    end

    // stage b: reciprocal partial products
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ph_reg[l] <= 55'(p_reg[l][31:16]) * 55'(recip);
            pl_reg[l] <= 55'(p_reg[l][15:0]) * 55'(recip);
        end
        x2_b_reg  <= x2_a_reg;
        sum_b_reg <= sum_a_reg;
        neg_b_reg <= neg_a_reg;
    end

    // stage c: finish the quotient and accumulate
    always_comb
    begin
        logic [71:0] full;
        logic [X_W-1:0] q;
        bus_next.x2  = x2_b_reg;
        bus_next.neg = neg_b_reg;
        for (int l = 0; l < LANES; l++)
        begin
            full = (72'(ph_reg[l]) << 16) + 72'(pl_reg[l]);
            q = X_W'(full >> REC_SHIFT);
            bus_next.term[l] = q;
            if (sub_term)
            begin
                bus_next.sum[l] = SUM_W'($signed(sum_b_reg[l]) - $signed(SUM_W'(q)));
            end
            else
            begin
                bus_next.sum[l] = SUM_W'($signed(sum_b_reg[l]) + $signed(SUM_W'(q)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign valid_out = valid_reg[2];
    assign bus_out   = bus_reg;

    // quotient never exceeds the dividend of the step
    a_term_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (bus_next.term[0] <= $past(p_reg[0])))
        else $error("series term grew");
    a_x2_carried: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |=> (x2_b_reg == $past(x2_a_reg)))
        else $error("x2 not carried");
    a_neg_carried: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (bus_next.neg == neg_b_reg))
        else $error("sign flags lost");

endmodule

`default_nettype wire

// ===== bench/euler_direction_vectors_core_tb.sv =====
// ----------------------------------------------------------------------------
// euler_direction_vectors_core_tb
// Drives pitch/yaw/roll angle transactions in random bursts and checks all
// nine direction vector components against a fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_direction_vectors_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edv_pkg::*;

    localparam int LATENCY    = 31;
    localparam int MAX_CYCLES = 200000;

    typedef struct {
        logic [IN_W-1:0] pitch;
        logic [IN_W-1:0] yaw;
        logic [IN_W-1:0] roll;
    } angles_t;

    typedef struct {
        logic [OUT_W-1:0] v [9];
    } vectors_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [IN_W-1:0] pitch_angle;
    logic [IN_W-1:0] yaw_angle;
    logic [IN_W-1:0] roll_angle;
    logic done;
    logic signed [OUT_W-1:0] forward_x, forward_y, forward_z;
    logic signed [OUT_W-1:0] right_x, right_y, right_z;
    logic signed [OUT_W-1:0] up_x, up_y, up_z;

    angles_t  angle_queue [$];
    vectors_t vector_queue [$];
    int       error_count;
    int       cycle_count;
    bit       stim_done;
    bit       hold_off;
    int       gap_left;
    int       burst_left;

    euler_direction_vectors_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .done(done),
        .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sine over one quarter turn, q30
    function automatic longint quarter_sin(longint unsigned u);
        longint unsigned x, x2, term;
        longint sum;
        x = (u * 64'd1686629713) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k & 1) sum -= term;
            else sum += term;
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
        return sum;
    endfunction

    function automatic longint sin_q30(longint unsigned a);
        longint unsigned quarter, quad, off;
        longint s;
        quarter = 64'd1 << (ANGLE_BITS - 2);
        a = a & ((64'd1 << ANGLE_BITS) - 1);
        quad = a >> (ANGLE_BITS - 2);
        off = a & (quarter - 1);
        s = quad[0] ? quarter_sin(quarter - off) : quarter_sin(off);
        return quad[1] ? -s : s;
    endfunction

    function automatic longint cos_q30(longint unsigned a);
        return sin_q30(a + (64'd1 << (ANGLE_BITS - 2)));
    endfunction

    // q30 product, rounded half away from zero
    function automatic longint qmul(longint a, longint b);
        longint unsigned ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [OUT_W-1:0] round_out(longint v);
        longint unsigned m;
        longint r;
        if (v > (64'sd1 << 30)) v = 64'sd1 << 30;
        if (v < -(64'sd1 << 30)) v = -(64'sd1 << 30);
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << (30 - FRAC_BITS - 1))) >> (30 - FRAC_BITS);
        r = v < 0 ? -longint'(m) : longint'(m);
        return r[OUT_W-1:0];
    endfunction

    function automatic vectors_t direction_vectors(angles_t a);
        vectors_t e;
        longint sp, cp, sy, cy, sr, cr;
        sp = sin_q30(a.pitch); cp = cos_q30(a.pitch);
        sy = sin_q30(a.yaw);   cy = cos_q30(a.yaw);
        sr = sin_q30(a.roll);  cr = cos_q30(a.roll);
        e.v[0] = round_out(-qmul(cp, sy));
        e.v[1] = round_out(sp);
        e.v[2] = round_out(-qmul(cp, cy));
        e.v[3] = round_out(qmul(cr, cy));
        e.v[4] = round_out(qmul(sr, cy));
        e.v[5] = round_out(-sy);
        e.v[6] = round_out(qmul(qmul(sp, sy), cr) - qmul(cy, sr));
        e.v[7] = round_out(qmul(cp, cr));
        e.v[8] = round_out(qmul(qmul(sp, cy), cr) + qmul(sy, sr));
        return e;
    endfunction

    task automatic report(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic add_item(logic [IN_W-1:0] p, logic [IN_W-1:0] y, logic [IN_W-1:0] r);
        angles_t a;
        a.pitch = p;
        a.yaw = y;
        a.roll = r;
        angle_queue.push_back(a);
    endtask

    // random angle, biased toward quadrant edges now and then
    function automatic logic [IN_W-1:0] rand_angle();
        logic [IN_W-1:0] a;
        a = IN_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            a = {a[15:14], 14'd0} + IN_W'($urandom_range(0, 2)) - IN_W'(1);
        return a;
    endfunction

    // driver: bursts and gaps, with one drain hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pitch_angle <= '0;
            yaw_angle <= '0;
            roll_angle <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!(start && busy))
        begin
            if (angle_queue.size() != 0 && !hold_off && gap_left == 0 &&
                !(start && busy))
            begin
                angles_t a;
                a = angle_queue.pop_front();
                vector_queue.push_back(direction_vectors(a));
                start <= 1'b1;
                pitch_angle <= a.pitch;
                yaw_angle <= a.yaw;
                roll_angle <= a.roll;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                start <= 1'b0;
                pitch_angle <= IN_W'($urandom);
                yaw_angle <= IN_W'($urandom);
                roll_angle <= IN_W'($urandom);
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // monitor: compare each done transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            vectors_t e;
            logic [OUT_W-1:0] got [9];
            got = '{forward_x, forward_y, forward_z, right_x, right_y, right_z,
                    up_x, up_y, up_z};
            if (vector_queue.size() == 0)
                report("result with no transaction pending");
            else
            begin
                e = vector_queue.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== e.v[i])
                        report($sformatf("component %0d got %0d expected %0d",
                                         i, $signed(got[i]), $signed(e.v[i])));
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        error_count = 0;
        cycle_count = 0;
        stim_done = 0;
        hold_off = 0;
        rst_n = 1'b0;

        // directed: extremes, quadrant boundaries, high bits
        add_item(16'h0000, 16'h0000, 16'h0000);
        add_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_item(16'h4000, 16'h4000, 16'h4000);
        add_item(16'h8000, 16'h8000, 16'h8000);
        add_item(16'hC000, 16'hC000, 16'hC000);
        add_item(16'h3FFF, 16'h4001, 16'hBFFF);
        add_item(16'h7FFF, 16'h8001, 16'hC001);
        add_item(16'h2000, 16'h6000, 16'hA000);
        add_item(16'hE000, 16'h2000, 16'h4000);
        add_item(16'h5555, 16'hAAAA, 16'h5555);
        add_item(16'hAAAA, 16'h5555, 16'hAAAA);
        add_item(16'h0001, 16'hC000, 16'h8000);
        add_item(16'h4000, 16'h0000, 16'hC000);
        add_item(16'hC000, 16'h4000, 16'h0000);
        add_item(16'h1234, 16'hFEDC, 16'h0F0F);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // first half, then wait for drain
        for (int i = 0; i < 650; i++)
            add_item(rand_angle(), rand_angle(), rand_angle());
        wait (angle_queue.size() == 0);
        @(posedge clk);
        hold_off = 1;
        wait (vector_queue.size() == 0);
        @(posedge clk);
        hold_off = 0;
        for (int i = 0; i < 700; i++)
            add_item(rand_angle(), rand_angle(), rand_angle());
        wait (angle_queue.size() == 0);
        @(posedge clk);
        wait (vector_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
